FILE: src/mbrnn_pkg.sv
// shared widths and helpers for the rectangle corner distance bound block
// no dependencies; used by mbrnn_isqrt and mbr_min_exist_nn_distance_unit
`default_nettype none

package mbrnn_pkg;

    // port width of every coordinate field, unsigned q12.4
    localparam int IN_W       = 16;
    // coordinate bits in use
    localparam int COORD_BITS = 16;
    localparam int CW         = COORD_BITS;
    // one squared axis difference
    localparam int SQ_W       = 2 * CW;
    // squared distance, sum of two squares
    localparam int RAD_W      = SQ_W + 1;
    // radicand padded to an even number of bits
    localparam int RAD_PW     = RAD_W + (RAD_W % 2);
    localparam int ROOT_W     = RAD_PW / 2;
    localparam int REM_W      = ROOT_W + 2;
    // result port
    localparam int OUT_W      = 17;
    localparam logic [63:0] OUT_MAX = 64'd131071;

    typedef logic [CW-1:0]    t_coord;
    typedef logic [SQ_W-1:0]  t_sq;
    typedef logic [RAD_W-1:0] t_dist;
    typedef logic [ROOT_W-1:0] t_root;

    function automatic t_coord abs_diff(input t_coord a, input t_coord b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic t_dist dmin(input t_dist a, input t_dist b);
        return (b < a) ? b : a;
    endfunction

    function automatic t_dist dmax(input t_dist a, input t_dist b);
        return (a < b) ? b : a;
    endfunction

endpackage

`default_nettype wire

FILE: src/mbrnn_isqrt.sv
// pipelined floor square root, one root bit per register stage
// depends on mbrnn_pkg for radicand and root widths
`default_nettype none

module mbrnn_isqrt (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_vld,
    input  wire mbrnn_pkg::t_dist     i_rad,
    output logic                      o_vld,
    output mbrnn_pkg::t_root          o_root
);
    import mbrnn_pkg::*;

    logic                r_vld  [ROOT_W];
    logic [REM_W-1:0]    r_rem  [ROOT_W];
    logic [ROOT_W-1:0]   r_root [ROOT_W];
    logic [RAD_PW-1:0]   r_rad  [ROOT_W];

    logic [RAD_PW-1:0]   w_rad_in;

    assign w_rad_in = RAD_PW'(i_rad);

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic                v_in;
        logic [REM_W-1:0]    rem_in;
        logic [ROOT_W-1:0]   root_in;
        logic [RAD_PW-1:0]   rad_in;
        logic [REM_W+1:0]    cur;
        logic [REM_W+1:0]    trial;
        logic                ge;
        logic [REM_W-1:0]    n_rem;
        logic [ROOT_W-1:0]   n_root;

        if (k == 0) begin : g_first
            assign v_in    = i_vld;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = w_rad_in;
        end else begin : g_next
            assign v_in    = r_vld[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign rad_in  = r_rad[k-1];
        end

        // bring down the next digit pair and try root*4+1
        assign cur    = {rem_in, rad_in[RAD_PW-1 -: 2]};
        assign trial  = (REM_W + 2)'({root_in, 2'b01});
        assign ge     = (cur >= trial);
        assign n_rem  = ge ? REM_W'(cur - trial) : REM_W'(cur);
        assign n_root = {root_in[ROOT_W-2:0], ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= v_in;
            end
            r_rem[k]  <= n_rem;
            r_root[k] <= n_root;
            r_rad[k]  <= rad_in << 2;
        end
    end

    assign o_vld  = r_vld[ROOT_W-1];
    assign o_root = r_root[ROOT_W-1];

endmodule

`default_nettype wire

FILE: src/mbr_min_exist_nn_distance_unit.sv
// rectangle corner min/max distance bound, top level
// depends on mbrnn_pkg and mbrnn_isqrt
`default_nettype none

// a start beat passes the data stages and then the square root stages before it shows on o_done
// throughput: one rectangle pair per cycle; busy stays low, the pipeline never stalls
// depth is set by the square root, one root bit per stage over a 34-bit radicand
// reset: synchronous, active low, clears the valid bits; data registers are not reset
// results are shown for one cycle under o_done and the receiver cannot hold them off

module mbr_min_exist_nn_distance_unit (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        start,
    output logic                       busy,
    input  wire  [mbrnn_pkg::IN_W-1:0] i_p_x_low,
    input  wire  [mbrnn_pkg::IN_W-1:0] i_p_x_high,
    input  wire  [mbrnn_pkg::IN_W-1:0] i_p_y_low,
    input  wire  [mbrnn_pkg::IN_W-1:0] i_p_y_high,
    input  wire  [mbrnn_pkg::IN_W-1:0] i_c_x_low,
    input  wire  [mbrnn_pkg::IN_W-1:0] i_c_x_high,
    input  wire  [mbrnn_pkg::IN_W-1:0] i_c_y_low,
    input  wire  [mbrnn_pkg::IN_W-1:0] i_c_y_high,
    output logic                       o_done,
    output logic [mbrnn_pkg::OUT_W-1:0] o_bound_distance
);
    import mbrnn_pkg::*;

    localparam int LATENCY = 6 + ROOT_W;

    // coordinates, index 0 is the low bound and 1 the high bound
    t_coord px [2];
    t_coord py [2];
    t_coord cx [2];
    t_coord cy [2];

    // valid bit of each stage
    logic   r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;

    // stage 1: axis differences, [c index][p index]
    t_coord r_dx [2][2];
    t_coord r_dy [2][2];
    // stage 2: squared axis differences
    t_sq    r_sqx [2][2];
    t_sq    r_sqy [2][2];
    // stage 3: squared distances, [c x][c y][p x][p y]
    t_dist  r_d [2][2][2][2];
    // stage 4: min and max within each pair of p corners sharing an x
    t_dist  r_plo [2][2][2];
    t_dist  r_phi [2][2][2];
    // stage 5: second smallest per c corner
    t_dist  r_sec [2][2];
    // stage 6: largest of the four
    t_dist  r_best;

    logic   w_sq_vld;
    t_root  w_root;

    assign busy = 1'b0;

    assign px[0] = CW'(i_p_x_low);
    assign px[1] = CW'(i_p_x_high);
    assign py[0] = CW'(i_p_y_low);
    assign py[1] = CW'(i_p_y_high);
    assign cx[0] = CW'(i_c_x_low);
    assign cx[1] = CW'(i_c_x_high);
    assign cy[0] = CW'(i_c_y_low);
    assign cy[1] = CW'(i_c_y_high);

    // valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    // data pipeline: a subtract stage, a multiply stage, an add stage, then compare stages
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 2; a++) begin
            for (int b = 0; b < 2; b++) begin
                r_dx[a][b]  <= abs_diff(cx[a], px[b]);
                r_dy[a][b]  <= abs_diff(cy[a], py[b]);
                // one 16x16 square per difference
                r_sqx[a][b] <= SQ_W'(r_dx[a][b] * r_dx[a][b]);
                r_sqy[a][b] <= SQ_W'(r_dy[a][b] * r_dy[a][b]);
            end
        end

        // corner (cx[a], cy[b]) to corner (px[c], py[e])
        for (int a = 0; a < 2; a++) begin
            for (int b = 0; b < 2; b++) begin
                for (int c = 0; c < 2; c++) begin
                    for (int e = 0; e < 2; e++) begin
                        r_d[a][b][c][e] <= RAD_W'(r_sqx[a][c]) + RAD_W'(r_sqy[b][e]);
                    end
                end
            end
        end

        // sort each pair, then second smallest of four is
        // min(larger of the two minima, smaller of the two maxima)
        for (int a = 0; a < 2; a++) begin
            for (int b = 0; b < 2; b++) begin
                for (int c = 0; c < 2; c++) begin
                    r_plo[a][b][c] <= dmin(r_d[a][b][c][0], r_d[a][b][c][1]);
                    r_phi[a][b][c] <= dmax(r_d[a][b][c][0], r_d[a][b][c][1]);
                end
                r_sec[a][b] <= dmin(dmax(r_plo[a][b][0], r_plo[a][b][1]),
                                    dmin(r_phi[a][b][0], r_phi[a][b][1]));
            end
        end

        r_best <= dmax(dmax(r_sec[0][0], r_sec[0][1]), dmax(r_sec[1][0], r_sec[1][1]));
    end

    mbrnn_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_v6),
        .i_rad   (r_best),
        .o_vld   (w_sq_vld),
        .o_root  (w_root)
    );

    // saturate only matters for coordinates wider than 16 bits
    assign o_done           = w_sq_vld;
    assign o_bound_distance = (64'(w_root) > OUT_MAX) ? OUT_W'(OUT_MAX) : OUT_W'(w_root);

    // every accepted beat comes out after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LATENCY o_done)
        else $error("result beat missing after fixed latency");

    // the kept maximum covers every corner value of the previous stage
    a_best_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 |=> (r_best >= $past(r_sec[0][0])) && (r_best >= $past(r_sec[0][1]))
              && (r_best >= $past(r_sec[1][0])) && (r_best >= $past(r_sec[1][1])))
        else $error("bound below a corner value");

    // c corner [0][0]: second smallest lies between the smaller minimum and the first maximum
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |=> (r_sec[0][0] >= dmin($past(r_plo[0][0][0]), $past(r_plo[0][0][1])))
              && (r_sec[0][0] <= $past(r_phi[0][0][0])))
        else $error("second smallest outside its bounds");

endmodule

`default_nettype wire

FILE: test/mbr_min_exist_nn_distance_unit_tb.sv
// testbench for the rectangle corner min/max distance bound unit
// needs mbrnn_pkg and mbr_min_exist_nn_distance_unit; self-checking against a local predictor
`timescale 1ns / 100ps

module mbr_min_exist_nn_distance_unit_tb;

    // cycles of silence on both handshakes before the run is called hung
    localparam int WATCHDOG_LIMIT = 2000;
    // longer than the pipe, for the drain at the end
    localparam int DRAIN_CYCLES   = 30;
    localparam int RANDOM_PAIRS   = 1700;

    typedef logic [mbrnn_pkg::IN_W-1:0]  coord_in_t;
    typedef logic [mbrnn_pkg::OUT_W-1:0] bound_t;

    // one rectangle pair as it crosses the start handshake
    typedef struct packed {
        coord_in_t p_x_low;
        coord_in_t p_x_high;
        coord_in_t p_y_low;
        coord_in_t p_y_high;
        coord_in_t c_x_low;
        coord_in_t c_x_high;
        coord_in_t c_y_low;
        coord_in_t c_y_high;
    } rect_pair_t;

    // keeps the bounds still owed by the pipe and checks each done beat against them
    class nn_bound_tracker;
        bound_t expected_bounds[$];
        int     fails;

        function new();
            fails = 0;
        endfunction

        // exact squared distance between two points, wide enough for coords up to 32 bits
        function logic [65:0] corner_dist2(logic [63:0] ax, logic [63:0] ay,
                                           logic [63:0] bx, logic [63:0] by);
            logic [65:0] dx;
            logic [65:0] dy;
            dx = (ax > bx) ? ax - bx : bx - ax;
            dy = (ay > by) ? ay - by : by - ay;
            return dx * dx + dy * dy;
        endfunction

        function bound_t predict_bound(rect_pair_t r);
            logic [63:0] px[2];
            logic [63:0] py[2];
            logic [63:0] cx[2];
            logic [63:0] cy[2];
            logic [65:0] d[4];
            logic [65:0] worst;
            logic [65:0] second;
            logic [67:0] rem;
            logic [67:0] root;
            logic [67:0] trial;
            int          lo_idx;
            bit          have;

            // only the low COORD_BITS of each field take part
            px[0] = 64'(mbrnn_pkg::t_coord'(r.p_x_low));
            px[1] = 64'(mbrnn_pkg::t_coord'(r.p_x_high));
            py[0] = 64'(mbrnn_pkg::t_coord'(r.p_y_low));
            py[1] = 64'(mbrnn_pkg::t_coord'(r.p_y_high));
            cx[0] = 64'(mbrnn_pkg::t_coord'(r.c_x_low));
            cx[1] = 64'(mbrnn_pkg::t_coord'(r.c_x_high));
            cy[0] = 64'(mbrnn_pkg::t_coord'(r.c_y_low));
            cy[1] = 64'(mbrnn_pkg::t_coord'(r.c_y_high));

            worst  = '0;
            second = '0;
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++)
                    d[j] = corner_dist2(cx[i >> 1], cy[i & 1], px[j >> 1], py[j & 1]);
                // drop one copy of the smallest, ties stay as separate entries
                lo_idx = 0;
                for (int j = 1; j < 4; j++)
                    if (d[j] < d[lo_idx])
                        lo_idx = j;
                have = 1'b0;
                for (int j = 0; j < 4; j++) begin
                    if (j != lo_idx && (!have || d[j] < second)) begin
                        second = d[j];
                        have   = 1'b1;
                    end
                end
                if (worst < second)
                    worst = second;
            end

            // floor square root, two radicand bits per step
            rem  = '0;
            root = '0;
            for (int k = 32; k >= 0; k--) begin
                rem   = (rem << 2) | 68'(worst[2*k +: 2]);
                trial = (root << 2) | 68'd1;
                if (rem >= trial) begin
                    rem  = rem - trial;
                    root = (root << 1) | 68'd1;
                end else begin
                    root = root << 1;
                end
            end
            if (root > 68'(mbrnn_pkg::OUT_MAX))
                root = 68'(mbrnn_pkg::OUT_MAX);
            return root[mbrnn_pkg::OUT_W-1:0];
        endfunction

        function void note_pair(rect_pair_t r);
            expected_bounds.insert(expected_bounds.size(), predict_bound(r));
        endfunction

        function void check_bound(bound_t actual);
            bound_t want;
            if (expected_bounds.size() == 0) begin
                fails++;
                if (fails <= 10)
                    $display("unexpected done beat: bound %0d with nothing pending", actual);
            end else begin
                want = expected_bounds.pop_front();
                if (actual !== want) begin
                    fails++;
                    if (fails <= 10)
                        $display("bound mismatch: expected %0d, got %0d", want, actual);
                end
            end
        endfunction
    endclass

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    coord_in_t i_p_x_low  = '0;
    coord_in_t i_p_x_high = '0;
    coord_in_t i_p_y_low  = '0;
    coord_in_t i_p_y_high = '0;
    coord_in_t i_c_x_low  = '0;
    coord_in_t i_c_x_high = '0;
    coord_in_t i_c_y_low  = '0;
    coord_in_t i_c_y_high = '0;
    logic      busy;
    logic      o_done;
    bound_t    o_bound_distance;

    nn_bound_tracker bounds = new();

    int idle_cycles  = 0;
    int no_idle_left = 0;

    always #10 i_clk = ~i_clk;

    mbr_min_exist_nn_distance_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_p_x_low        (i_p_x_low),
        .i_p_x_high       (i_p_x_high),
        .i_p_y_low        (i_p_y_low),
        .i_p_y_high       (i_p_y_high),
        .i_c_x_low        (i_c_x_low),
        .i_c_x_high       (i_c_x_high),
        .i_c_y_low        (i_c_y_low),
        .i_c_y_high       (i_c_y_high),
        .o_done           (o_done),
        .o_bound_distance (o_bound_distance)
    );

    // result side: the receiver cannot stall, so every done beat is checked as it shows up
    // an x on o_done after reset counts as a beat and fails the check
    always @(posedge i_clk) begin
        if (i_rst_n && o_done !== 1'b0)
            bounds.check_bound(o_bound_distance);
    end

    // hang detector: any accepted beat on either side resets the count
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_done === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // present one pair and hold it until a start beat is taken
    // called right after a rising edge, so the new values land before the next one
    task automatic drive_rects(input coord_in_t pxl, input coord_in_t pxh,
                               input coord_in_t pyl, input coord_in_t pyh,
                               input coord_in_t cxl, input coord_in_t cxh,
                               input coord_in_t cyl, input coord_in_t cyh);
        rect_pair_t r;
        r = '{pxl, pxh, pyl, pyh, cxl, cxh, cyl, cyh};
        start      <= 1'b1;
        i_p_x_low  <= pxl;
        i_p_x_high <= pxh;
        i_p_y_low  <= pyl;
        i_p_y_high <= pyh;
        i_c_x_low  <= cxl;
        i_c_x_high <= cxh;
        i_c_y_low  <= cyl;
        i_c_y_high <= cyh;
        @(posedge i_clk);
        // busy is sampled before this edge's updates, i.e. the value the dut saw
        while (busy !== 1'b0)
            @(posedge i_clk);
        bounds.note_pair(r);
    endtask

    // drop start unless n is zero; the data lines carry junk meanwhile
    // start stays high across back-to-back beats so it is never lowered and raised in one step
    task automatic idle_for(input int n);
        if (n > 0) begin
            start      <= 1'b0;
            i_p_x_low  <= coord_in_t'($urandom);
            i_p_x_high <= coord_in_t'($urandom);
            i_p_y_low  <= coord_in_t'($urandom);
            i_p_y_high <= coord_in_t'($urandom);
            i_c_x_low  <= coord_in_t'($urandom);
            i_c_x_high <= coord_in_t'($urandom);
            i_c_y_low  <= coord_in_t'($urandom);
            i_c_y_high <= coord_in_t'($urandom);
            repeat (n) @(posedge i_clk);
        end
    endtask

    // mostly short gaps, a few long ones, and now and then a stretch of back-to-back beats
    function automatic int rand_gap();
        int unsigned sel;
        if (no_idle_left > 0) begin
            no_idle_left--;
            return 0;
        end
        sel = $urandom_range(0, 99);
        if (sel < 2)
            no_idle_left = $urandom_range(20, 80);
        if (sel < 55)
            return 0;
        if (sel < 88)
            return $urandom_range(1, 3);
        if (sel < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    initial begin : stimulus
        coord_in_t   v[8];
        coord_in_t   tmp;
        int unsigned mode;
        int unsigned base;
        int unsigned axis;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed pairs
        // all corners on the origin, and all on the top of the range
        drive_rects(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                    16'h0000, 16'h0000, 16'h0000, 16'h0000);
        idle_for(rand_gap());
        drive_rects(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        idle_for(rand_gap());
        // point rectangles at opposite ends: the largest bound there is
        drive_rects(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        idle_for(rand_gap());
        drive_rects(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'h0000, 16'h0000, 16'h0000, 16'h0000);
        idle_for(rand_gap());
        // both rectangles span the whole plane
        drive_rects(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
                    16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
        idle_for(rand_gap());
        // full p against a point c, and a point p in the middle of full c
        drive_rects(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
                    16'h0000, 16'h0000, 16'h0000, 16'h0000);
        idle_for(rand_gap());
        drive_rects(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                    16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
        idle_for(rand_gap());
        // low bound above high bound, on p, on c, on both
        drive_rects(16'hFFFF, 16'h0000, 16'hF000, 16'h0010,
                    16'h1234, 16'h5678, 16'h2222, 16'h3333);
        idle_for(rand_gap());
        drive_rects(16'h1000, 16'h2000, 16'h3000, 16'h4000,
                    16'hFFF0, 16'h0001, 16'h9000, 16'h0800);
        idle_for(rand_gap());
        drive_rects(16'hC000, 16'h4000, 16'hFFFF, 16'h0000,
                    16'hFFFF, 16'h0000, 16'hA000, 16'h1000);
        idle_for(rand_gap());
        // zero-width p against a point, zero-height c against a box
        drive_rects(16'h1234, 16'h1234, 16'h0000, 16'hFFFF,
                    16'h4000, 16'h4000, 16'h7000, 16'h7000);
        idle_for(rand_gap());
        drive_rects(16'h0100, 16'h0400, 16'h0100, 16'h0400,
                    16'h0000, 16'hFFFF, 16'h2000, 16'h2000);
        idle_for(rand_gap());
        // identical small rectangles, coinciding corners
        drive_rects(16'h000A, 16'h0014, 16'h000A, 16'h0014,
                    16'h000A, 16'h0014, 16'h000A, 16'h0014);
        idle_for(rand_gap());
        // c at the center of a square p: all four distances tie
        drive_rects(16'h1000, 16'h3000, 16'h1000, 16'h3000,
                    16'h2000, 16'h2000, 16'h2000, 16'h2000);
        idle_for(rand_gap());
        // alternating bit patterns
        drive_rects(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                    16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        idle_for(rand_gap());
        drive_rects(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                    16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
        idle_for(rand_gap());
        // far apart, well formed
        drive_rects(16'h0000, 16'h0100, 16'h0000, 16'h0100,
                    16'hF000, 16'hFFFF, 16'hF000, 16'hFFFF);
        idle_for(rand_gap());
        // c point tucked near one corner of p
        drive_rects(16'h0800, 16'h8800, 16'h0800, 16'h8800,
                    16'h0801, 16'h0801, 16'h0802, 16'h0802);
        idle_for(rand_gap());
        // one step in from the extremes, and around the midpoint
        drive_rects(16'h0001, 16'hFFFE, 16'h0001, 16'hFFFE,
                    16'hFFFE, 16'h0001, 16'h0001, 16'hFFFE);
        idle_for(rand_gap());
        drive_rects(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                    16'h8000, 16'h7FFF, 16'h0001, 16'h0001);
        idle_for(rand_gap());

        // random pairs
        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            mode = $urandom_range(0, 99);
            base = $urandom_range(0, 16'hFDFF);
            for (int k = 0; k < 8; k++) begin
                if (mode < 55) begin
                    // whole range
                    v[k] = coord_in_t'($urandom);
                end else if (mode < 80) begin
                    // clustered in a small window: near ties and small distances
                    v[k] = coord_in_t'(base + $urandom_range(0, 511));
                end else begin
                    // edges of the range and bit boundaries
                    case ($urandom_range(0, 7))
                        0:       v[k] = 16'h0000;
                        1:       v[k] = 16'h0001;
                        2:       v[k] = 16'hFFFE;
                        3:       v[k] = 16'hFFFF;
                        4:       v[k] = 16'h7FFF;
                        5:       v[k] = 16'h8000;
                        6:       v[k] = 16'hAAAA;
                        default: v[k] = 16'h5555;
                    endcase
                end
            end
            // most pairs are proper rectangles, low at or below high
            if (mode >= 20) begin
                for (int a = 0; a < 8; a += 2) begin
                    if (v[a] > v[a+1]) begin
                        tmp    = v[a];
                        v[a]   = v[a+1];
                        v[a+1] = tmp;
                    end
                end
            end
            // flatten some axes to lines and points
            if (mode >= 45 && mode < 55) begin
                for (int a = 0; a < 8; a += 2)
                    if ($urandom_range(0, 1) == 1)
                        v[a+1] = v[a];
            end
            // now and then flip one axis of the pair
            if ($urandom_range(0, 19) == 0) begin
                axis       = 2 * $urandom_range(0, 3);
                tmp        = v[axis];
                v[axis]    = v[axis+1];
                v[axis+1]  = tmp;
            end
            drive_rects(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
            idle_for(rand_gap());
        end
        idle_for(1);

        // wait out the pipe; a lost beat leaves this to the watchdog
        while (bounds.expected_bounds.size() != 0)
            @(posedge i_clk);
        // stray beats after the last one would still be caught here
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (bounds.fails == 0 && bounds.expected_bounds.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
